// ===== rtl/column_aggregate_engine_assert.svh =====
// Assertion macros for the column aggregate engine.
// Used by column_aggregate_engine.sv; expects clk and rst_n in scope.
`ifndef COLUMN_AGGREGATE_ENGINE_ASSERT_SVH
`define COLUMN_AGGREGATE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CAE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("column_aggregate_engine assertion failed");
// next-cycle implication
`define CAE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("column_aggregate_engine assertion failed");
`else
`define CAE_ASSERT_IMP(lbl, ante, cons)
`define CAE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cae_pkg.sv =====
// Shared types, constants and codes for the column aggregate engine.
// No dependencies; imported by every cae module.
`timescale 1ns / 1ps
`default_nettype none
package cae_pkg;
  localparam int NUM_W       = 48;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = 17;
  localparam int STORE_DEPTH = 256;
  localparam int STORE_CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int SHIFT_W     = $clog2(STORE_DEPTH / 2 + 1);
  localparam int DIV_STEPS   = NUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int PROD_W      = CNT_W + 7;
  localparam int MODE_W      = 4;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam num_t NUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
  localparam num_t NUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};
  localparam num_t NUM_ONE = num_t'(1) <<< FRAC_BITS;
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};
  localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);

  // aggregate mode codes
  localparam logic [MODE_W-1:0] MODE_NONE       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_FILLED     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_EMPTY      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SUM        = 4'd4;
  localparam logic [MODE_W-1:0] MODE_AVG        = 4'd5;
  localparam logic [MODE_W-1:0] MODE_MIN        = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MAX        = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MEDIAN     = 4'd8;
  localparam logic [MODE_W-1:0] MODE_RANGE      = 4'd9;
  localparam logic [MODE_W-1:0] MODE_PCT_EMPTY  = 4'd10;
  localparam logic [MODE_W-1:0] MODE_PCT_FILLED = 4'd11;

  // row kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_END,
    S_SHIFT,
    S_DIV,
    S_LOAD
  } state_t;

  // sort chain control
  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } chain_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/cae_cell.sv =====
// One cell of the sorted insertion chain: one stored value and its occupied bit.
// Depends on cae_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cae_cell import cae_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_ctl_t ctl,
  input  wire num_t       ins_val,
  input  wire logic       prev_gt,
  input  wire logic       prev_occ,
  input  wire num_t       prev_val,
  input  wire num_t       next_val,
  output      logic       gt,
  output      logic       occ,
  output      num_t       val
);
  num_t val_r, val_nxt;
  logic occ_r, occ_nxt;

  // empty cells count as larger than anything
  assign gt  = !occ_r || (val_r > ins_val);
  assign occ = occ_r;
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctl.shift) begin
      val_nxt = next_val;
    end else if (ctl.ins && gt) begin
      val_nxt = prev_gt ? prev_val : ins_val;
      occ_nxt = occ_r || prev_occ;
    end
    if (ctl.clr) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/cae_chain.sv =====
// Row of cae_cell instances forming an ascending sorted store.
// Depends on cae_pkg and cae_cell.
`timescale 1ns / 1ps
`default_nettype none
module cae_chain import cae_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_ctl_t ctl,
  input  wire num_t       ins_val,
  output      num_t       head0,
  output      num_t       head1
);
  logic gt_w  [STORE_DEPTH];
  logic occ_w [STORE_DEPTH];
  num_t val_w [STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic p_gt, p_occ;
    num_t p_val, n_val;
    if (i == 0) begin : g_first
      assign p_gt  = 1'b0;
      assign p_occ = 1'b1;
      assign p_val = ins_val;
    end else begin : g_rest
      assign p_gt  = gt_w[i-1];
      assign p_occ = occ_w[i-1];
      assign p_val = val_w[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign n_val = val_w[i];
    end else begin : g_mid
      assign n_val = val_w[i+1];
    end
    cae_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .ins_val  (ins_val),
      .prev_gt  (p_gt),
      .prev_occ (p_occ),
      .prev_val (p_val),
      .next_val (n_val),
      .gt       (gt_w[i]),
      .occ      (occ_w[i]),
      .val      (val_w[i])
    );
  end

  assign head0 = val_w[0];
  assign head1 = val_w[1];
endmodule
`default_nettype wire

// ===== rtl/cae_divider.sv =====
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cae_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cae_divider import cae_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire cnt_t             divisor,
  output      logic             done,
  output      logic [NUM_W-1:0] quotient
);
  logic [NUM_W-1:0]     dq_r, dq_nxt;
  cnt_t                 rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // one trial subtraction per step
  always_comb begin
    trial   = {rem_r, dq_r[NUM_W-1]};
    fits    = trial >= {1'b0, divisor};
    rem_nxt = fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
    dq_nxt  = {dq_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;
endmodule
`default_nettype wire

// ===== rtl/column_aggregate_engine.sv =====
// Top level of the column aggregate engine: counters, accumulators, control.
// Depends on cae_pkg, cae_chain, cae_divider and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "column_aggregate_engine_assert.svh"
// Rows are taken one per cycle: the sorted insertion chain and the running
// counters, sum, min and max all update in the cycle a row beat is accepted.
// A beat with last_row set stops input while the result is formed: states
// S_END and S_LOAD for most modes, with S_SHIFT between them for median, which
// shifts the chain down to its middle entries, or S_DIV for average and the
// percent modes, which run the serial divider. The result sits in an output
// register, so rows of the next column are accepted while it waits to be
// taken, except that another last beat is held until the register is free.
// The user must write agg_mode only while the block is idle, which the block
// itself does not enforce. There is no clearing pass after reset.
module column_aggregate_engine import cae_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [MODE_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_holds_row,
  input  wire logic [1:0]        in_row_kind,
  input  wire logic              in_value_empty,
  input  wire num_t              in_row_number,
  input  wire logic              in_box_checked,
  input  wire logic              in_last_row,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      num_t              out_aggregate_value,
  output      logic              out_store_overflow
);
  state_t state_r, state_nxt;
  logic [MODE_W-1:0]      mode_r;
  cnt_t                   row_r, filled_r, numcnt_r;
  num_t                   sum_r, min_r, max_r, res_r;
  logic [STORE_CNT_W-1:0] count_r;
  logic                   ovf_r;
  logic [SHIFT_W-1:0]     shift_r;
  logic                   neg_r;
  logic                   out_valid_r, out_ovf_r;
  num_t                   out_val_r;

  logic        beat, numeric, filled, full, out_free;
  num_t        num_v;
  logic [NUM_W:0] sum_ext, rng_ext, med_ext;
  num_t        sum_sat, rng_sat;
  cnt_t        empty_cnt, pct_part;
  logic        none, go_shift, go_div;
  logic [PROD_W-1:0] pct_prod;
  logic [NUM_W-1:0]  div_dividend, div_q;
  cnt_t        div_divisor;
  logic        div_start, div_done;
  num_t        head0, head1, med_val, direct_val;
  logic [SHIFT_W-1:0] mid, shift_init;
  chain_ctl_t  ctl;

  // row decode
  always_comb begin
    filled  = in_holds_row && (in_row_kind != KIND_NONE) && !in_value_empty;
    numeric = in_holds_row && (((in_row_kind == KIND_NUMBER) && !in_value_empty)
              || (in_row_kind == KIND_CHECK));
    num_v   = (in_row_kind == KIND_CHECK) ? (in_box_checked ? NUM_ONE : '0)
                                          : in_row_number;
    full    = count_r == STORE_CNT_W'(STORE_DEPTH);
    beat    = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
  end

  // saturating sum and range
  always_comb begin
    sum_ext = {sum_r[NUM_W-1], sum_r} + {num_v[NUM_W-1], num_v};
    if (sum_ext[NUM_W] != sum_ext[NUM_W-1]) begin
      sum_sat = sum_ext[NUM_W] ? NUM_MIN : NUM_MAX;
    end else begin
      sum_sat = sum_ext[NUM_W-1:0];
    end
    rng_ext = {max_r[NUM_W-1], max_r} - {min_r[NUM_W-1], min_r};
    if (rng_ext[NUM_W] != rng_ext[NUM_W-1]) begin
      rng_sat = rng_ext[NUM_W] ? NUM_MIN : NUM_MAX;
    end else begin
      rng_sat = rng_ext[NUM_W-1:0];
    end
  end

  // end-of-column decode
  always_comb begin
    none       = numcnt_r == '0;
    empty_cnt  = row_r - filled_r;
    pct_part   = (mode_r == MODE_PCT_EMPTY) ? empty_cnt : filled_r;
    pct_prod   = PROD_W'(pct_part) * PCT_SCALE;
    go_shift   = (mode_r == MODE_MEDIAN) && !none;
    go_div     = ((mode_r == MODE_AVG) && !none) ||
                 (((mode_r == MODE_PCT_EMPTY) || (mode_r == MODE_PCT_FILLED)) &&
                  (row_r != '0));
    mid        = count_r[STORE_CNT_W-1:1];
    shift_init = count_r[0] ? mid : mid - 1'b1;
    if (mode_r == MODE_AVG) begin
      div_dividend = sum_r[NUM_W-1] ? NUM_W'(-sum_r) : sum_r;
      div_divisor  = numcnt_r;
    end else begin
      div_dividend = {{(NUM_W-PROD_W-FRAC_BITS){1'b0}}, pct_prod, {FRAC_BITS{1'b0}}};
      div_divisor  = row_r;
    end
    med_ext = {head0[NUM_W-1], head0} + {head1[NUM_W-1], head1};
    med_val = count_r[0] ? head0 : med_ext[NUM_W:1];
  end

  // results that need no extra work
  always_comb begin
    unique case (mode_r)
      MODE_COUNT:  direct_val = num_t'({row_r, {FRAC_BITS{1'b0}}});
      MODE_FILLED: direct_val = num_t'({filled_r, {FRAC_BITS{1'b0}}});
      MODE_EMPTY:  direct_val = num_t'({empty_cnt, {FRAC_BITS{1'b0}}});
      MODE_SUM:    direct_val = none ? '0 : sum_r;
      MODE_MIN:    direct_val = none ? '0 : min_r;
      MODE_MAX:    direct_val = none ? '0 : max_r;
      MODE_RANGE:  direct_val = none ? '0 : rng_sat;
      default:     direct_val = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (beat && in_last_row) state_nxt = S_END;
      S_END: begin
        if (go_shift) state_nxt = S_SHIFT;
        else if (go_div) state_nxt = S_DIV;
        else state_nxt = S_LOAD;
      end
      S_SHIFT: if (shift_r == '0) state_nxt = S_LOAD;
      S_DIV:   if (div_done) state_nxt = S_LOAD;
      S_LOAD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE) && (!in_last_row || !out_valid_r);
    ctl.ins   = beat && numeric && !full;
    ctl.shift = (state_r == S_SHIFT) && (shift_r != '0);
    ctl.clr   = (state_r == S_LOAD) && out_free;
    div_start = (state_r == S_END) && !go_shift && go_div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // column accumulators
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      row_r    <= '0;
      filled_r <= '0;
      numcnt_r <= '0;
      sum_r    <= '0;
      min_r    <= NUM_MAX;
      max_r    <= NUM_MIN;
      count_r  <= '0;
      ovf_r    <= 1'b0;
    end else if (beat && in_holds_row) begin
      if (row_r != CNT_MAX) row_r <= row_r + 1'b1;
      if (filled && filled_r != CNT_MAX) filled_r <= filled_r + 1'b1;
      if (numeric) begin
        if (numcnt_r != CNT_MAX) numcnt_r <= numcnt_r + 1'b1;
        sum_r <= sum_sat;
        if (num_v < min_r) min_r <= num_v;
        if (num_v > max_r) max_r <= num_v;
        if (full) ovf_r <= 1'b1;
        else count_r <= count_r + 1'b1;
      end
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (state_r == S_END) begin
      res_r   <= direct_val;
      shift_r <= shift_init;
      neg_r   <= sum_r[NUM_W-1] && (mode_r == MODE_AVG);
    end else if (state_r == S_SHIFT) begin
      if (shift_r == '0) res_r <= med_val;
      else shift_r <= shift_r - 1'b1;
    end else if (state_r == S_DIV && div_done) begin
      res_r <= neg_r ? num_t'(-div_q) : num_t'(div_q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.clr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      out_val_r <= res_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_aggregate_value = out_val_r;
  assign out_store_overflow  = out_ovf_r;

  cae_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .ins_val (num_v),
    .head0   (head0),
    .head1   (head1)
  );

  cae_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // checks
  `CAE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= STORE_CNT_W'(STORE_DEPTH))
  `CAE_ASSERT_IMP(a_ovf_full, ovf_r, full)
  `CAE_ASSERT_IMP(a_out_rise, $rose(out_valid_r), $past(state_r == S_LOAD))
  `CAE_ASSERT_NXT(a_div_start, div_start, state_r == S_DIV)
endmodule
`default_nettype wire
